/* rtl/core/assert_macros.svh */
// Assertion macros shared by the ARP cache RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ARPC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules that use the standard clk_i / rst_ni names.
`define ARPC_ASSERT(label, prop, msg) `ARPC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/core/arpc_pkg.sv */
// Package for the ARP cache and responder: constants, codes and shared types.
// No dependencies; imported by arpc_cmd_fifo, arpc_front, arpc_back and the top level.
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;
  localparam int unsigned TsW  = 64;

  localparam logic [15:0]     ArpHwEther   = 16'h0001;
  localparam logic [15:0]     ArpProtoIpv4 = 16'h0800;
  localparam logic [7:0]      ArpHwLen     = 8'd6;
  localparam logic [7:0]      ArpProtoLen  = 8'd4;
  localparam logic [15:0]     ArpOpRequest = 16'h0001;
  localparam logic [MacW-1:0] MacBcast     = {MacW{1'b1}};

  typedef enum logic [1:0] {
    KIND_PKT     = 2'd0,
    KIND_RESOLVE = 2'd1,
    KIND_TICK    = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    REG_LOCAL_IP  = 1'b0,
    REG_LOCAL_MAC = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_TICK_DONE = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_ACCEPTED  = 3'd2,
    ST_REPLY     = 3'd3,
    ST_RES_HIT   = 3'd4,
    ST_RES_MISS  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TXOP_NONE    = 2'd0,
    TXOP_REQUEST = 2'd1,
    TXOP_REPLY   = 2'd2
  } tx_op_e;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_DROP,
    CMD_PKT,
    CMD_RESOLVE
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_e;

  // Classified request handed from the front end to the table engine.
  typedef struct packed {
    cmd_e            op;
    logic [IpW-1:0]  ip;          // sender IP for packets, query IP for resolves
    logic [MacW-1:0] mac;         // sender MAC for packets
    logic            to_us;       // target IP equals our address
    logic            is_request;  // ARP opcode is request
  } cmd_t;

  typedef struct packed {
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
    logic [TsW-1:0]  ts;
  } entry_t;

  typedef struct packed {
    status_e         status;
    logic            send_frame;
    tx_op_e          tx_op;
    logic [MacW-1:0] tx_eth_dest;
    logic [MacW-1:0] tx_target_mac;
    logic [IpW-1:0]  tx_target_ip;
    logic [MacW-1:0] resolved_mac;
    logic            learned;
  } res_t;

endpackage

/* rtl/core/arpc_if.sv */
// Handshake interfaces for the request and result channels.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        frame_complete;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [7:0]  hw_len;
  logic [7:0]  proto_len;
  logic [15:0] opcode;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [31:0] query_ip;

  modport source (output valid, kind, frame_complete, hw_type, proto_type, hw_len,
                  proto_len, opcode, src_mac, src_ip, dst_ip, query_ip,
                  input ready);
  modport sink (input valid, kind, frame_complete, hw_type, proto_type, hw_len,
                proto_len, opcode, src_mac, src_ip, dst_ip, query_ip,
                output ready);
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        send_frame;
  logic [1:0]  tx_op;
  logic [47:0] tx_eth_dest;
  logic [47:0] tx_target_mac;
  logic [31:0] tx_target_ip;
  logic [47:0] resolved_mac;
  logic        learned;

  modport source (output valid, status, send_frame, tx_op, tx_eth_dest, tx_target_mac,
                  tx_target_ip, resolved_mac, learned, input ready);
  modport sink (input valid, status, send_frame, tx_op, tx_eth_dest, tx_target_mac,
                tx_target_ip, resolved_mac, learned, output ready);
endinterface

/* rtl/core/arpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module arpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/arpc_cmd_fifo.sv */
// Two-entry command queue between the front end and the table engine.
// Depends on arpc_pkg for cmd_t.
`timescale 1ns / 1ps
module arpc_cmd_fifo
  import arpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);
  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end
endmodule

/* rtl/core/arpc_front.sv */
// Front end: accepts requests, validates ARP headers and classifies them.
// Depends on arpc_pkg and the arpc_in_if interface.
`timescale 1ns / 1ps
module arpc_front
  import arpc_pkg::*;
(
  arpc_in_if.sink        in_req_i,
  input  logic [IpW-1:0] local_ip_i,
  input  logic           q_full_i,
  output logic           push_o,
  output cmd_t           push_cmd_o
);
  logic hdr_ok;

  assign in_req_i.ready = !q_full_i;
  assign push_o         = in_req_i.valid && !q_full_i;

  // A packet is only usable with a full header, Ethernet/IPv4 types and lengths,
  // and a configured local address.
  assign hdr_ok = in_req_i.frame_complete
               && (in_req_i.hw_type == ArpHwEther)
               && (in_req_i.proto_type == ArpProtoIpv4)
               && (in_req_i.hw_len == ArpHwLen)
               && (in_req_i.proto_len == ArpProtoLen)
               && (local_ip_i != '0);

  always_comb begin
    push_cmd_o.mac        = in_req_i.src_mac;
    push_cmd_o.to_us      = (in_req_i.dst_ip == local_ip_i);
    push_cmd_o.is_request = (in_req_i.opcode == ArpOpRequest);
    push_cmd_o.ip         = in_req_i.src_ip;
    case (kind_e'(in_req_i.kind))
      KIND_PKT: begin
        push_cmd_o.op = hdr_ok ? CMD_PKT : CMD_DROP;
      end
      KIND_RESOLVE: begin
        push_cmd_o.op = CMD_RESOLVE;
        push_cmd_o.ip = in_req_i.query_ip;
      end
      KIND_TICK: begin
        push_cmd_o.op = CMD_TICK;
      end
      default: begin
        push_cmd_o.op = CMD_DROP;
      end
    endcase
  end
endmodule

/* rtl/core/arpc_back.sv */
// Table engine: scans the ARP table for each packet or resolve request, updates it and builds results.
// Depends on arpc_pkg, arpc_ram, arpc_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module arpc_back
  import arpc_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t q_head_i,
  output logic q_pop_o,
  arpc_out_if.source out_res_o
);
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] CntEnd = CntW'(TableEntries);

  back_state_e state_q, state_d;
  cmd_t            cur_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q;
  logic [TableEntries-1:0] valid_q;
  logic [TsW-1:0]  tick_q;

  logic            hit_q, free_q, lru_init_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, lru_idx_q;
  logic [MacW-1:0] hit_mac_q;
  logic [TsW-1:0]  lru_ts_q;

  entry_t          rd_entry;
  logic            e_vld, e_match, e_free, e_lru;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic            res_load;
  res_t            res_d, res_q;
  logic            out_vld_q;
  logic            out_free;
  logic            start;
  logic            learn;
  logic            tick_inc;

  arpc_ram #(
    .Width($bits(entry_t)),
    .Depth(TableEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q[IdxW-1:0]),
    .rdata_o(rd_entry)
  );

  assign out_free = !out_vld_q || out_res_o.ready;
  assign start    = (state_q == BK_IDLE) && !q_empty_i && out_free;

  // Per-entry compare against the registered read data.
  assign e_vld   = rd_vld_q && valid_q[rd_idx_q];
  assign e_match = e_vld && !hit_q && (rd_entry.ip == cur_q.ip);
  assign e_free  = rd_vld_q && !valid_q[rd_idx_q] && !free_q;
  assign e_lru   = e_vld && (!lru_init_q || (rd_entry.ts < lru_ts_q));
  assign rd_vld_d = (state_q == BK_SCAN) && (cnt_q < CntEnd);
  assign learn    = (cur_q.ip != '0) && (hit_q || cur_q.to_us);

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      BK_IDLE: begin
        cnt_d = '0;
        if (start && (q_head_i.op == CMD_PKT || q_head_i.op == CMD_RESOLVE)) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (cnt_q < CntEnd) begin
          cnt_d = cnt_q + CntW'(1);
        end else if (rd_vld_q) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Outputs: queue pop, table write and result build.
  always_comb begin
    q_pop_o   = start;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = '{ip: cur_q.ip, mac: cur_q.mac, ts: tick_q};
    res_load  = 1'b0;
    tick_inc  = 1'b0;
    res_d     = '{status: ST_DROPPED, send_frame: 1'b0, tx_op: TXOP_NONE,
                  tx_eth_dest: '0, tx_target_mac: '0, tx_target_ip: '0,
                  resolved_mac: '0, learned: 1'b0};
    case (state_q)
      BK_IDLE: begin
        if (start && q_head_i.op == CMD_TICK) begin
          res_load     = 1'b1;
          tick_inc     = 1'b1;
          res_d.status = ST_TICK_DONE;
        end else if (start && q_head_i.op == CMD_DROP) begin
          res_load = 1'b1;
        end
      end
      BK_DONE: begin
        res_load = 1'b1;
        if (cur_q.op == CMD_PKT) begin
          res_d.status = ST_ACCEPTED;
          if (learn) begin
            ram_we        = 1'b1;
            res_d.learned = 1'b1;
            ram_waddr     = hit_q ? hit_idx_q : (free_q ? free_idx_q : lru_idx_q);
          end
          if (cur_q.is_request && cur_q.to_us) begin
            res_d.status        = ST_REPLY;
            res_d.send_frame    = 1'b1;
            res_d.tx_op         = TXOP_REPLY;
            res_d.tx_eth_dest   = cur_q.mac;
            res_d.tx_target_mac = cur_q.mac;
            res_d.tx_target_ip  = cur_q.ip;
          end
        end else if (hit_q) begin
          ram_we             = 1'b1;
          ram_wdata.mac      = hit_mac_q;
          res_d.status       = ST_RES_HIT;
          res_d.resolved_mac = hit_mac_q;
        end else begin
          res_d.status       = ST_RES_MISS;
          res_d.send_frame   = 1'b1;
          res_d.tx_op        = TXOP_REQUEST;
          res_d.tx_eth_dest  = MacBcast;
          res_d.tx_target_ip = cur_q.ip;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      valid_q   <= '0;
      tick_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      if (tick_inc) begin
        tick_q <= tick_q + TsW'(1);
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IdxW-1:0];
    if (res_load) begin
      res_q <= res_d;
    end
    if (start) begin
      cur_q      <= q_head_i;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      lru_init_q <= 1'b0;
    end else begin
      if (e_match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
        hit_mac_q <= rd_entry.mac;
      end
      if (e_free) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (e_lru) begin
        lru_init_q <= 1'b1;
        lru_idx_q  <= rd_idx_q;
        lru_ts_q   <= rd_entry.ts;
      end
    end
  end

  assign out_res_o.valid         = out_vld_q;
  assign out_res_o.status        = res_q.status;
  assign out_res_o.send_frame    = res_q.send_frame;
  assign out_res_o.tx_op         = res_q.tx_op;
  assign out_res_o.tx_eth_dest   = res_q.tx_eth_dest;
  assign out_res_o.tx_target_mac = res_q.tx_target_mac;
  assign out_res_o.tx_target_ip  = res_q.tx_target_ip;
  assign out_res_o.resolved_mac  = res_q.resolved_mac;
  assign out_res_o.learned       = res_q.learned;

  `ARPC_ASSERT(a_scan_bound, (state_q == BK_SCAN) |-> (cnt_q <= CntEnd), "scan count overran")
  `ARPC_ASSERT(a_write_in_done, ram_we |-> (state_q == BK_DONE), "table written outside done")
  `ARPC_ASSERT(a_done_loads, (state_q == BK_DONE) |=> out_vld_q, "done produced no result")
endmodule

/* rtl/core/arp_cache_and_responder_unit.sv */
// Top level of the ARP cache and responder: config register and the three parts.
// Depends on arpc_pkg, arpc_if, arpc_front, arpc_cmd_fifo and arpc_back.
`timescale 1ns / 1ps
//
//  Channel     | Dir | Handshake     | Carries
//  ------------+-----+---------------+------------------------------------------
//  in_req_i    | in  | valid/ready   | ARP packet, resolve query or time tick
//  out_res_o   | out | valid/ready   | one result per request
//  cfg_*_i     | in  | write enable  | local IP (index 0), local MAC (index 1)
//
// A tick or a dropped request is handled by the engine in its idle state, with no
// table scan. A packet or resolve query is handled by a scan of the table through
// the single read port of the entry RAM. Reset clears valid bits, tick counter and
// handshake state at once; no clearing pass is needed. Requests are taken into a
// two-entry queue while the engine works or a result waits, so the input stalls
// only when the queue is full.
module arp_cache_and_responder_unit
  import arpc_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arpc_in_if.sink     in_req_i,
  arpc_out_if.source  out_res_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);
  logic [IpW-1:0] local_ip_q;
  logic           push, q_full, q_empty, q_pop;
  cmd_t           push_cmd, q_head;

  // Only our IP is stored here; the results carry no sender MAC of their own, so a
  // local MAC write has no effect.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
    end else if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == REG_LOCAL_IP) begin
      local_ip_q <= cfg_data_i[IpW-1:0];
    end
  end

  // Front end validates the header and classifies each request.
  arpc_front u_front (
    .in_req_i  (in_req_i),
    .local_ip_i(local_ip_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .push_cmd_o(push_cmd)
  );

  // Queue decouples acceptance from the table scan.
  arpc_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_o    (q_head)
  );

  // Engine scans the table, learns or refreshes entries and emits results.
  arpc_back #(
    .TableEntries(TableEntries)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .out_res_o(out_res_o)
  );
endmodule
